@@ src/lkvc_pkg.sv @@
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants of the LRU key-value cache
// Entry count, field widths, command codes and derived index/count widths.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int ENTRIES = 16;
  localparam int CAP_W   = 5;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [IDX_W-1:0]        rank_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [CAP_W-1:0]        cap_t;
  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic signed [VAL_W-1:0] val_t;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_t;

  localparam cap_t CAPACITY_RESET = CAP_W'(16);
  localparam val_t MISS_VALUE     = '1;
  localparam val_t PUT_VALUE      = '0;

endpackage

@@ src/lkvc_req_if.sv @@
// ----------------------------------------------------------------------------
// lkvc_req_if: request channel of the LRU key-value cache
// Valid/ready handshake carrying a get or put command with key and value.
// ----------------------------------------------------------------------------
interface lkvc_req_if;
  logic              valid;
  logic              ready;
  lkvc_pkg::cmd_t    command;
  lkvc_pkg::key_t    key;
  lkvc_pkg::val_t    value;

  modport source (output valid, output command, output key, output value, input ready);
  modport sink   (input valid, input command, input key, input value, output ready);
endinterface

@@ src/lkvc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// lkvc_rsp_if: response channel of the LRU key-value cache
// Valid/ready handshake carrying the hit flag, read data and eviction flag.
// ----------------------------------------------------------------------------
interface lkvc_rsp_if;
  logic              valid;
  logic              ready;
  logic              found;
  lkvc_pkg::val_t    read_value;
  logic              evicted;

  modport source (output valid, output found, output read_value, output evicted,
                  input ready);
  modport sink   (input valid, input found, input read_value, input evicted,
                  output ready);
endinterface

@@ src/lru_key_value_cache.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value store, LRU replacement
// Pipeline: input register, then one pass of lookup and update logic into the
//   response register.
// Throughput: one request per cycle while the response side does not stall;
//   the per-entry key compare and rank update all happen in that single pass.
// Reset: synchronous; all entries empty, ranks zero, capacity back to 16.
//   No clearing pass, the cache takes requests in the cycle after reset.
// ----------------------------------------------------------------------------
module lru_key_value_cache (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  lkvc_pkg::cap_t       cfg_wdata,
  lkvc_req_if.sink             req,
  lkvc_rsp_if.source           rsp
);

  // Configuration
  lkvc_pkg::cap_t  capacity;

  // Input register
  logic            in_valid;
  lkvc_pkg::cmd_t  in_cmd;
  lkvc_pkg::key_t  in_key;
  lkvc_pkg::val_t  in_value;

  // Response register
  logic            out_valid;
  logic            out_found;
  lkvc_pkg::val_t  out_read_value;
  logic            out_evicted;

  // Cache state: keys and values are only read behind a valid bit
  lkvc_pkg::key_t  entry_keys   [lkvc_pkg::ENTRIES];
  lkvc_pkg::val_t  entry_values [lkvc_pkg::ENTRIES];
  logic [lkvc_pkg::ENTRIES-1:0] entry_valid;
  lkvc_pkg::rank_t recency_rank [lkvc_pkg::ENTRIES];
  lkvc_pkg::cnt_t  valid_count;

  // Lookup / update pass
  logic            fire;
  logic            is_put;
  logic [lkvc_pkg::ENTRIES-1:0] hit_vec;
  logic            hit;
  lkvc_pkg::idx_t  hit_idx;
  lkvc_pkg::idx_t  free_idx;
  lkvc_pkg::idx_t  evict_idx;
  lkvc_pkg::rank_t last_rank;
  logic            room;
  logic            do_insert;
  logic            do_replace;
  logic            do_touch;
  lkvc_pkg::idx_t  tgt_idx;
  lkvc_pkg::rank_t old_rank;
  lkvc_pkg::val_t  rd_value;

  // --------------------------------------------------------------------------
  // Handshake: the pass runs when the input register holds a request and the
  // response register is empty or being drained this cycle.
  // --------------------------------------------------------------------------
  assign fire      = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || fire;

  assign rsp.valid      = out_valid;
  assign rsp.found      = out_found;
  assign rsp.read_value = out_read_value;
  assign rsp.evicted    = out_evicted;

  // Capacity register: written only while the cache is idle (the user's rule; not enforced here)
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lkvc_pkg::CAPACITY_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  // Input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  // Input register payload: capture on each transfer
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_cmd   <= req.command;
      in_key   <= req.key;
      in_value <= req.value;
    end
  end

  // --------------------------------------------------------------------------
  // Associative lookup: compare the key against every entry in parallel and
  // take the lowest matching slot. Also pick the lowest free slot and the
  // least recently used slot (rank equal to count minus one).
  // --------------------------------------------------------------------------
  assign last_rank = lkvc_pkg::IDX_W'(valid_count - lkvc_pkg::CNT_W'(1));

  always_comb begin
    hit_vec   = '0;
    hit_idx   = '0;
    free_idx  = '0;
    evict_idx = '0;
    for (int i = lkvc_pkg::ENTRIES - 1; i >= 0; i--) begin
      hit_vec[i] = entry_valid[i] && (entry_keys[i] == in_key);
      if (hit_vec[i]) begin
        hit_idx = lkvc_pkg::IDX_W'(i);
      end
      if (!entry_valid[i]) begin
        free_idx = lkvc_pkg::IDX_W'(i);
      end
      if (entry_valid[i] && (recency_rank[i] == last_rank)) begin
        evict_idx = lkvc_pkg::IDX_W'(i);
      end
    end
  end

  assign hit    = |hit_vec;
  assign is_put = (in_cmd == lkvc_pkg::CMD_PUT);

  // Room for a new entry: below both the capacity register and the array size
  assign room = (lkvc_pkg::CMP_W'(valid_count) < lkvc_pkg::CMP_W'(capacity)) &&
                (valid_count < lkvc_pkg::CNT_W'(lkvc_pkg::ENTRIES));

  // Put miss with room fills a free slot; without room it overwrites the LRU
  // slot. With capacity zero and nothing stored, a put miss stores nothing.
  assign do_insert  = is_put && !hit && room;
  assign do_replace = is_put && !hit && !room && (valid_count != '0);
  assign do_touch   = hit || do_insert || do_replace;

  always_comb begin
    priority if (hit) begin
      tgt_idx  = hit_idx;
      old_rank = recency_rank[hit_idx];
    end else if (do_insert) begin
      tgt_idx  = free_idx;
      old_rank = last_rank;
    end else begin
      tgt_idx  = evict_idx;
      old_rank = last_rank;
    end
  end

  always_comb begin
    priority if (is_put) begin
      rd_value = lkvc_pkg::PUT_VALUE;
    end else if (hit) begin
      rd_value = entry_values[hit_idx];
    end else begin
      rd_value = lkvc_pkg::MISS_VALUE;
    end
  end

  // --------------------------------------------------------------------------
  // State update: the touched slot becomes rank zero. On insert every valid
  // entry ages; otherwise only entries more recent than the touched one age.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      valid_count <= '0;
      for (int j = 0; j < lkvc_pkg::ENTRIES; j++) begin
        recency_rank[j] <= '0;
      end
    end else if (fire && do_touch) begin
      for (int j = 0; j < lkvc_pkg::ENTRIES; j++) begin
        if (lkvc_pkg::IDX_W'(j) == tgt_idx) begin
          recency_rank[j] <= '0;
        end else if (entry_valid[j] && (do_insert || (recency_rank[j] < old_rank))) begin
          recency_rank[j] <= recency_rank[j] + lkvc_pkg::IDX_W'(1);
        end
      end
      if (do_insert) begin
        entry_valid[tgt_idx] <= 1'b1;
        valid_count          <= valid_count + lkvc_pkg::CNT_W'(1);
      end
    end
  end

  // Key and value storage: written by any put that lands in a slot
  always_ff @(posedge clk) begin
    if (fire && is_put && do_touch) begin
      entry_keys[tgt_idx]   <= in_key;
      entry_values[tgt_idx] <= in_value;
    end
  end

  // Response register control: load on the pass, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_found      <= hit;
      out_read_value <= rd_value;
      out_evicted    <= is_put && !hit && !room;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(entry_valid) == int'(valid_count))
    else $error("valid_count disagrees with the valid bits");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    valid_count <= lkvc_pkg::CNT_W'(lkvc_pkg::ENTRIES))
    else $error("valid_count exceeds the entry count");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (fire && do_insert) |=> (valid_count == $past(valid_count) + lkvc_pkg::CNT_W'(1)))
    else $error("insert did not grow valid_count");

  a_hit_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (fire && hit) |=> (valid_count == $past(valid_count)))
    else $error("hit changed valid_count");

endmodule

@@ sim/lru_key_value_cache_tb.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache_tb: self-checking bench for the LRU key-value cache
// Drives gets and puts over the request channel and predicts every response
// with an in-bench LRU store. It runs directed corner cases, then random
// phases at several capacities under varied idle, stall and back-pressure
// patterns.
// ----------------------------------------------------------------------------
module lru_key_value_cache_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lkvc_pkg::*;

  localparam int HALF_PERIOD      = 10;
  localparam int RESET_CYCLES     = 5;
  localparam int LONG_HOLD_CYCLES = 64;
  localparam int TAIL_CYCLES      = 10;
  localparam int PHASE_ITEMS      = 150;
  localparam int REPORT_LIMIT     = 10;

  // One request as queued for the driver. Set drain_first to hold the
  // request back until every earlier response has come back.
  typedef struct {
    cmd_t command;
    key_t key;
    val_t value;
    bit   drain_first;
  } cache_request_t;

  // One response as the cache should return it.
  typedef struct {
    logic found;
    val_t read_value;
    logic evicted;
  } cache_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  cap_t cfg_wdata = '0;

  lkvc_req_if req_ch ();
  lkvc_rsp_if rsp_ch ();

  lru_key_value_cache dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always #HALF_PERIOD clk = ~clk;

  // --------------------------------------------------------------------------
  // Shadow LRU store: mirrors what the cache should hold after every request.
  // Age 0 is the most recently used line; used lines hold ages 0..used-1.
  // --------------------------------------------------------------------------
  key_t  line_key   [ENTRIES] = '{default: '0};
  val_t  line_value [ENTRIES] = '{default: '0};
  bit    line_used  [ENTRIES] = '{default: 1'b0};
  rank_t line_age   [ENTRIES] = '{default: '0};
  cnt_t  lines_used  = '0;
  cap_t  cap_setting = CAPACITY_RESET;

  // Bench state shared between the stimulus, the driver and the monitor
  cache_request_t request_q[$];
  cache_reply_t   reply_q[$];
  int results_due    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  logic hold_start   = 1'b0;
  int hold_left      = 0;

  int error_count        = 0;
  int get_count          = 0;
  int put_count          = 0;
  int hit_count          = 0;
  int evict_count        = 0;
  int reply_count        = 0;
  int backpressure_count = 0;

  // Make line s the most recent; every used line that was newer ages by one.
  function automatic void touch_line(int s);
    rank_t old_age;
    int j;
    old_age = line_age[s];
    for (j = 0; j < ENTRIES; j++) begin
      if (line_used[j] && j != s && line_age[j] < old_age) begin
        line_age[j] = line_age[j] + 1'b1;
      end
    end
    line_age[s] = '0;
  endfunction

  // Apply one request to the shadow store and return the response it causes.
  function automatic cache_reply_t lookup_and_update(cmd_t command, key_t key, val_t value);
    cache_reply_t r;
    int limit;
    int hit_line;
    int slot;
    int i;
    r.found      = 1'b0;
    r.read_value = PUT_VALUE;
    r.evicted    = 1'b0;
    limit        = (int'(cap_setting) > ENTRIES) ? ENTRIES : int'(cap_setting);
    hit_line     = -1;
    slot         = -1;

    // Keys are unique among used lines, so the first match is the only one.
    for (i = 0; i < ENTRIES; i++) begin
      if (hit_line < 0 && line_used[i] && line_key[i] == key) begin
        hit_line = i;
      end
    end
    r.found = (hit_line >= 0);

    if (command == CMD_GET) begin
      if (r.found) begin
        r.read_value = line_value[hit_line];
        touch_line(hit_line);
      end else begin
        r.read_value = MISS_VALUE;
      end
    end else if (r.found) begin
      line_value[hit_line] = value;
      touch_line(hit_line);
    end else if (int'(lines_used) < limit) begin
      // Room left: take the lowest free line and age everything else.
      for (i = 0; i < ENTRIES; i++) begin
        if (slot < 0 && !line_used[i]) begin
          slot = i;
        end
      end
      if (slot >= 0) begin
        for (i = 0; i < ENTRIES; i++) begin
          if (line_used[i]) begin
            line_age[i] = line_age[i] + 1'b1;
          end
        end
        line_key[slot]   = key;
        line_value[slot] = value;
        line_used[slot]  = 1'b1;
        line_age[slot]   = '0;
        lines_used       = lines_used + 1'b1;
      end
    end else if (lines_used == 0) begin
      // Zero capacity on an empty store: the new pair goes straight out.
      r.evicted = 1'b1;
    end else begin
      // Full or over capacity: overwrite the oldest line in place.
      for (i = 0; i < ENTRIES; i++) begin
        if (slot < 0 && line_used[i] && int'(line_age[i]) == int'(lines_used) - 1) begin
          slot = i;
        end
      end
      if (slot >= 0) begin
        line_key[slot]   = key;
        line_value[slot] = value;
        touch_line(slot);
        r.evicted = 1'b1;
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: offer the head of request_q, hold it until the transfer,
  // then advance. Idle cycles come at random per send_idle_pct.
  // --------------------------------------------------------------------------
  initial begin
    req_ch.valid   = 1'b0;
    req_ch.command = CMD_GET;
    req_ch.key     = '0;
    req_ch.value   = '0;
    rsp_ch.ready   = 1'b0;
  end

  always @(posedge clk) begin : drive_requests
    logic offer;
    logic sent_now;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      // Either idle or the current request transfers at this edge.
      sent_now = req_ch.valid;
      if (sent_now) begin
        request_q.delete(0);
      end
      offer = 1'b0;
      if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        // A draining request also waits out the one that just left, whose
        // response is not counted in results_due until the next edge.
        offer = !(request_q[0].drain_first && (sent_now || results_due != 0));
      end
      req_ch.valid <= offer;
      if (offer) begin
        req_ch.command <= request_q[0].command;
        req_ch.key     <= request_q[0].key;
        req_ch.value   <= request_q[0].value;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Response ready: random stalls per recv_stall_pct, plus a long hold-off
  // that the stimulus starts with a one-cycle hold_start pulse.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_start) begin
      hold_left <= LONG_HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on every request transfer, then check every response
  // transfer against the oldest prediction. Requests are handled first so a
  // prediction is always queued before its response could be compared.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch_channels
    cache_reply_t want;
    cache_reply_t got;
    int delta;
    if (!rst) begin
      delta = 0;
      if (req_ch.valid && !req_ch.ready) begin
        backpressure_count++;
      end
      if (req_ch.valid && req_ch.ready) begin
        want = lookup_and_update(req_ch.command, req_ch.key, req_ch.value);
        reply_q.push_back(want);
        delta++;
        if (req_ch.command == CMD_GET) begin
          get_count++;
        end else begin
          put_count++;
        end
        if (want.found) begin
          hit_count++;
        end
        if (want.evicted) begin
          evict_count++;
        end
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.found      = rsp_ch.found;
        got.read_value = rsp_ch.read_value;
        got.evicted    = rsp_ch.evicted;
        reply_count++;
        if (reply_q.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("[%0t] response %0d with none outstanding: found=%0b value=%0d evicted=%0b",
                     $realtime, reply_count, got.found, got.read_value, got.evicted);
          end
        end else begin
          want = reply_q.pop_front();
          delta--;
          if (got.found !== want.found || got.read_value !== want.read_value ||
              got.evicted !== want.evicted) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
              $display("[%0t] response %0d mismatch: expected found=%0b value=%0d evicted=%0b",
                       $realtime, reply_count, want.found, want.read_value, want.evicted);
              $display("               got      found=%0b value=%0d evicted=%0b",
                       got.found, got.read_value, got.evicted);
            end
          end
        end
      end
      results_due <= results_due + delta;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Extreme 32-bit patterns: most negative, most positive, all ones, zero.
  function automatic val_t corner_word();
    case ($urandom_range(3))
      0:       return val_t'(32'h8000_0000);
      1:       return val_t'(32'h7FFF_FFFF);
      2:       return val_t'(32'hFFFF_FFFF);
      default: return val_t'(32'h0000_0000);
    endcase
  endfunction

  task automatic queue_item(cmd_t command, logic [31:0] key, logic [31:0] value);
    cache_request_t it;
    it.command     = command;
    it.key         = key_t'(key);
    it.value       = val_t'(value);
    it.drain_first = 1'b0;
    request_q.push_back(it);
  endtask

  // Wait until the driver has nothing left and every response is back.
  // Sample at the falling edge to stay clear of the clocked processes.
  task automatic drain_all();
    do begin
      @(negedge clk);
    end while (request_q.size() != 0 || results_due != 0);
  endtask

  // Write the capacity register on an idle cache, then return at a falling
  // edge so the caller can queue the next batch cleanly.
  task automatic write_capacity(int cap);
    drain_all();
    @(posedge clk);
    cfg_we      <= 1'b1;
    cfg_wdata   <= cap_t'(cap);
    cap_setting = cap_t'(cap);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Random gets and puts. Most keys come from a small pool sized a little
  // above the effective capacity, so hits, updates and evictions all occur;
  // the rest are fresh random keys that mostly miss.
  task automatic queue_random(int n, int eff_cap);
    key_t pool[$];
    cache_request_t it;
    int span;
    int j;
    span = eff_cap + 1 + $urandom_range(eff_cap / 2 + 1);
    for (j = 0; j < span; j++) begin
      pool.push_back(($urandom_range(7) == 0) ? key_t'(corner_word()) : key_t'($urandom()));
    end
    for (j = 0; j < n; j++) begin
      it.command = $urandom_range(1) ? CMD_PUT : CMD_GET;
      if ($urandom_range(99) < 85) begin
        it.key = pool[$urandom_range(span - 1)];
      end else begin
        it.key = ($urandom_range(3) == 0) ? key_t'(corner_word()) : key_t'($urandom());
      end
      it.value       = ($urandom_range(7) == 0) ? corner_word() : val_t'($urandom());
      it.drain_first = (j % 40 == 39);
      request_q.push_back(it);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int phase_cap  [8] = '{16, 3, 31, 8, 17, 1, 12, 5};
    int phase_send [8] = '{0, 68, 0, 7, 0, 68, 0, 7};
    int phase_recv [8] = '{0, 0, 68, 7, 0, 0, 68, 7};
    int p;
    int eff_cap;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Zero capacity on an empty cache: a put misses, reports an eviction and
    // stores nothing, so the key still misses afterwards.
    write_capacity(0);
    queue_item(CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_item(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_item(CMD_GET, 32'h8000_0000, 32'h0000_0000);

    // Two lines: fill, touch, evict the oldest, update in place, and read
    // back a stored all-ones value that looks like a miss code.
    write_capacity(2);
    queue_item(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_item(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_item(CMD_GET, 32'h8000_0000, 32'h1234_5678);
    queue_item(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_item(CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    queue_item(CMD_PUT, 32'h8000_0000, 32'h0000_0000);
    queue_item(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_item(CMD_GET, 32'h8000_0000, 32'h8000_0000);
    queue_item(CMD_PUT, 32'h0000_0000, 32'h5A5A_5A5A);

    // Capacity lowered below the lines in use: each missing put replaces the
    // oldest line and the count stays where it was.
    write_capacity(1);
    queue_item(CMD_PUT, 32'h0000_0001, 32'h0000_0001);
    queue_item(CMD_PUT, 32'h0000_0002, 32'h0000_0002);
    queue_item(CMD_GET, 32'h0000_0001, 32'h0000_0000);
    queue_item(CMD_GET, 32'h0000_0002, 32'h0000_0000);

    // Zero capacity with lines still in use behaves the same way.
    write_capacity(0);
    queue_item(CMD_PUT, 32'h0000_0003, 32'h0000_0003);
    queue_item(CMD_GET, 32'h0000_0003, 32'h0000_0000);

    // Random phases, each at its own capacity and idle pattern.
    for (p = 0; p < 8; p++) begin
      write_capacity(phase_cap[p]);
      send_idle_pct  = phase_send[p];
      recv_stall_pct = phase_recv[p];
      eff_cap = (phase_cap[p] > ENTRIES) ? ENTRIES : phase_cap[p];
      queue_random(PHASE_ITEMS, eff_cap);
      if (p == 4) begin
        // Hold responses off while the driver keeps offering, so the cache
        // fills its pipeline and pushes back on the request side.
        @(posedge clk);
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
      end
    end

    drain_all();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d requests (%0d gets, %0d puts) at capacities 0 through 31,",
             get_count + put_count, get_count, put_count);
    $display("with %0d hits, %0d evictions and %0d cycles of request back-pressure.",
             hit_count, evict_count, backpressure_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("%0d response errors", error_count);
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #(10_000_000);
    $display("watchdog expired with %0d responses outstanding", results_due);
    $display("FAIL");
    $finish;
  end

endmodule

@@ files.f @@
src/lkvc_pkg.sv
src/lkvc_req_if.sv
src/lkvc_rsp_if.sv
src/lru_key_value_cache.sv
sim/lru_key_value_cache_tb.sv
